@@ src/ccmd_pkg.sv @@
`timescale 1ns / 1ps

package ccmd_pkg;

    localparam int unsigned HEADWAY_MAX_STAGE = 3;
    localparam logic [3:0] HEADWAY_INIT_RESET = 4'd1;
    localparam int unsigned PCT_FULL = 100;

    localparam logic [1:0] ST_OFF      = 2'd0;
    localparam logic [1:0] ST_READY    = 2'd1;
    localparam logic [1:0] ST_ACTIVE   = 2'd2;
    localparam logic [1:0] ST_OVERRIDE = 2'd3;

    localparam int unsigned BTN_MAIN   = 0;
    localparam int unsigned BTN_SET    = 1;
    localparam int unsigned BTN_RESUME = 2;
    localparam int unsigned BTN_UP     = 3;
    localparam int unsigned BTN_DOWN   = 4;
    localparam int unsigned BTN_CANCEL = 5;
    localparam int unsigned BTN_HEAD   = 6;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_CLEAR = 3'd1;
    localparam logic [2:0] OP_SET   = 3'd2;
    localparam logic [2:0] OP_UP1   = 3'd3;
    localparam logic [2:0] OP_DOWN1 = 3'd4;
    localparam logic [2:0] OP_UP2   = 3'd5;
    localparam logic [2:0] OP_DOWN2 = 3'd6;

    typedef struct packed {
        logic [1:0] machine_state;
        logic [6:0] buttons;
        logic       brake_pedal;
        logic       park_brake;
        logic       accel_pedal;
        logic       gear_forward;
        logic       stand_still;
        logic       speed_stored;
        logic [8:0] display_speed;
        logic [8:0] set_speed;
        logic [2:0] stability_failures;
    } t_in_item;

    typedef struct packed {
        logic [1:0] display_state;
        logic       cmd_on;
        logic       cmd_off;
        logic       cmd_activate;
        logic       cmd_deactivate;
        logic [2:0] speed_operation;
        logic       start_confirm;
        logic [6:0] headway_percent;
        logic       degraded;
    } t_out_item;

endpackage

@@ src/ccmd_if.sv @@
`timescale 1ns / 1ps

interface ccmd_in_if;
    logic               valid;
    logic               ready;
    ccmd_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ccmd_out_if;
    logic                valid;
    logic                ready;
    ccmd_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ccmd_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/cruise_control_hmi_command_logic_core.sv @@
`timescale 1ns / 1ps

// Cruise control HMI command logic.
// i_in carries one control tick per transfer: machine state, buttons, pedals,
// gear, speeds and stability failures. o_out carries one result per tick:
// display state, on/off/activate/deactivate commands, speed operation,
// start confirmation, headway percent and the degraded flag.
// i_cfg writes the initial headway stage, loaded while the system is off.
// An input transfer is captured in the input register, and its result then
// passes to the result register, which drives o_out. Throughput: one tick per
// cycle while o_out.ready stays high, set by the single pass of
// decision logic between the two registers.
// Reset clears the valid flags of both pipeline registers, the previous
// buttons and the start confirmation, sets the initial headway stage to 1 and
// loads it as the current stage. i_in and i_cfg are not ready while reset is
// asserted; i_cfg is always ready otherwise.
// When the receiver stalls, the result register holds its transfer, the
// input register fills, and then i_in.ready drops until o_out.ready returns.
module cruise_control_hmi_command_logic_core #(
    parameter int unsigned HEADWAY_MAX_STAGE = ccmd_pkg::HEADWAY_MAX_STAGE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ccmd_in_if.sink            i_in,
    ccmd_out_if.source         o_out,
    ccmd_cfg_if.sink           i_cfg
);

    logic [6:0] w_pct_table [16];

    for (genvar g = 0; g < 16; g++) begin : g_pct
        localparam int unsigned RAW = (g * ccmd_pkg::PCT_FULL) / HEADWAY_MAX_STAGE;
        localparam int unsigned SAT = (RAW > ccmd_pkg::PCT_FULL) ? ccmd_pkg::PCT_FULL : RAW;
        assign w_pct_table[g] = 7'(SAT);
    end

    logic                r_s1_valid;
    ccmd_pkg::t_in_item  r_s1_item;
    logic                r_out_valid;
    ccmd_pkg::t_out_item r_out_item;
    logic [3:0]          r_head_init;
    logic [6:0]          r_last_buttons;
    logic [3:0]          r_head_stage;
    logic                r_confirm;

    ccmd_pkg::t_out_item n_out_item;
    logic [3:0]          n_head_stage;
    logic                n_confirm;
    logic                w_out_load;
    logic                w_s1_adv;

    assign w_out_load  = !r_out_valid || o_out.ready;
    assign w_s1_adv    = r_s1_valid && w_out_load;
    assign i_in.ready  = i_rst_n && (!r_s1_valid || w_out_load);
    assign i_cfg.ready = i_rst_n;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    always_comb begin
        logic [6:0] btn;
        logic [6:0] edges;
        logic [3:0] stage;
        logic       off;
        logic       act;
        logic       deact;
        btn          = r_s1_item.buttons;
        edges        = btn & ~r_last_buttons;
        stage        = r_head_stage;
        off          = 1'b0;
        act          = 1'b0;
        deact        = 1'b0;
        n_confirm    = r_confirm;
        n_out_item   = '0;
        n_out_item.speed_operation = ccmd_pkg::OP_NONE;

        if (r_s1_item.machine_state != ccmd_pkg::ST_OFF && edges[ccmd_pkg::BTN_HEAD]) begin
            if (r_head_stage == 4'(HEADWAY_MAX_STAGE)) begin
                stage = '0;
            end else begin
                stage = r_head_stage + 4'd1;
            end
        end

        case (r_s1_item.machine_state)
            ccmd_pkg::ST_OFF: begin
                n_out_item.cmd_on = btn[ccmd_pkg::BTN_MAIN];
                stage = r_head_init;
            end
            ccmd_pkg::ST_READY: begin
                off = !btn[ccmd_pkg::BTN_MAIN];
                act = (btn[ccmd_pkg::BTN_SET] || btn[ccmd_pkg::BTN_RESUME]
                       || btn[ccmd_pkg::BTN_UP] || btn[ccmd_pkg::BTN_DOWN])
                      && (!r_s1_item.brake_pedal || r_s1_item.stand_still)
                      && !r_s1_item.park_brake && r_s1_item.gear_forward;
                if (off) begin
                    n_out_item.speed_operation = ccmd_pkg::OP_CLEAR;
                end else if (act && (edges[ccmd_pkg::BTN_SET] || !r_s1_item.speed_stored)) begin
                    n_out_item.speed_operation = ccmd_pkg::OP_SET;
                end
            end
            default: begin
                deact = btn[ccmd_pkg::BTN_CANCEL] || r_s1_item.park_brake
                        || (r_s1_item.brake_pedal && !r_s1_item.stand_still)
                        || !r_s1_item.gear_forward;
                if (deact) begin
                    n_confirm = 1'b0;
                end else begin
                    n_confirm = btn[ccmd_pkg::BTN_RESUME] || r_s1_item.accel_pedal;
                    if (r_s1_item.machine_state == ccmd_pkg::ST_ACTIVE) begin
                        if (edges[ccmd_pkg::BTN_DOWN]) begin
                            n_out_item.speed_operation = ccmd_pkg::OP_DOWN2;
                        end else if (edges[ccmd_pkg::BTN_UP]) begin
                            n_out_item.speed_operation = ccmd_pkg::OP_UP2;
                        end else if (edges[ccmd_pkg::BTN_SET]) begin
                            n_out_item.speed_operation =
                                (r_s1_item.display_speed > r_s1_item.set_speed)
                                ? ccmd_pkg::OP_SET : ccmd_pkg::OP_DOWN1;
                        end else if (edges[ccmd_pkg::BTN_RESUME]) begin
                            n_out_item.speed_operation = ccmd_pkg::OP_UP1;
                        end
                    end else begin
                        if (edges[ccmd_pkg::BTN_SET]) begin
                            n_out_item.speed_operation = ccmd_pkg::OP_SET;
                        end else if (edges[ccmd_pkg::BTN_DOWN]) begin
                            n_out_item.speed_operation = ccmd_pkg::OP_DOWN2;
                        end else if (edges[ccmd_pkg::BTN_UP]) begin
                            n_out_item.speed_operation = ccmd_pkg::OP_UP2;
                        end else if (edges[ccmd_pkg::BTN_RESUME]) begin
                            n_out_item.speed_operation = ccmd_pkg::OP_UP1;
                        end
                    end
                end
            end
        endcase

        n_head_stage                = stage;
        n_out_item.display_state    = r_s1_item.machine_state;
        n_out_item.cmd_off          = off;
        n_out_item.cmd_activate     = act;
        n_out_item.cmd_deactivate   = deact;
        n_out_item.start_confirm    = n_confirm;
        n_out_item.headway_percent  = w_pct_table[stage];
        n_out_item.degraded         = |r_s1_item.stability_failures;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_head_init    <= ccmd_pkg::HEADWAY_INIT_RESET;
            r_last_buttons <= '0;
            r_head_stage   <= ccmd_pkg::HEADWAY_INIT_RESET;
            r_confirm      <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_head_init <= i_cfg.data;
            end
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_out_load) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_s1_adv) begin
                r_last_buttons <= r_s1_item.buttons;
                r_head_stage   <= n_head_stage;
                r_confirm      <= n_confirm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_item <= i_in.data;
        end
        if (w_s1_adv) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

@@ tb/cruise_control_hmi_command_logic_core_test.sv @@
`timescale 1ns / 1ps

module cruise_control_hmi_command_logic_core_test;
    import ccmd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_LIMIT = 100;
    localparam int RANDOM_PHASE_TICKS = 240;

    localparam logic [6:0] MASK_MAIN   = 7'd1 << BTN_MAIN;
    localparam logic [6:0] MASK_SET    = 7'd1 << BTN_SET;
    localparam logic [6:0] MASK_RESUME = 7'd1 << BTN_RESUME;
    localparam logic [6:0] MASK_UP     = 7'd1 << BTN_UP;
    localparam logic [6:0] MASK_DOWN   = 7'd1 << BTN_DOWN;
    localparam logic [6:0] MASK_CANCEL = 7'd1 << BTN_CANCEL;
    localparam logic [6:0] MASK_HEAD   = 7'd1 << BTN_HEAD;

    logic clk;
    logic rst_n;

    ccmd_in_if  in_ch ();
    ccmd_out_if out_ch ();
    ccmd_cfg_if cfg_ch ();

    cruise_control_hmi_command_logic_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Predictor state
    logic [3:0] hw_init;
    logic [3:0] hw_stage;
    logic [6:0] prev_btn;
    logic       confirm_q;

    t_out_item  expected_cmds[$];
    logic [1:0] walk_state;
    bit         steady;
    int         errors;
    int         cycles;

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_out_item hmi_command_for(input t_in_item it);
        t_out_item   r;
        logic [6:0]  b;
        logic [6:0]  rise;
        int unsigned pct;
        b = it.buttons;
        rise = b & ~prev_btn;
        r = '0;
        r.display_state = it.machine_state;
        case (it.machine_state)
            ST_OFF: begin
                r.cmd_on = b[BTN_MAIN];
                hw_stage = hw_init;
            end
            ST_READY: begin
                r.cmd_off = !b[BTN_MAIN];
                r.cmd_activate = (b[BTN_SET] | b[BTN_RESUME] | b[BTN_UP] | b[BTN_DOWN])
                                 && (!it.brake_pedal || it.stand_still)
                                 && !it.park_brake && it.gear_forward;
                if (r.cmd_off) begin
                    r.speed_operation = OP_CLEAR;
                end else if (r.cmd_activate && (rise[BTN_SET] || !it.speed_stored)) begin
                    r.speed_operation = OP_SET;
                end
            end
            default: begin
                r.cmd_deactivate = b[BTN_CANCEL] || it.park_brake
                                   || (it.brake_pedal && !it.stand_still) || !it.gear_forward;
                if (r.cmd_deactivate) begin
                    confirm_q = 1'b0;
                end else begin
                    confirm_q = b[BTN_RESUME] || it.accel_pedal;
                    if (it.machine_state == ST_ACTIVE) begin
                        if (rise[BTN_DOWN])        r.speed_operation = OP_DOWN2;
                        else if (rise[BTN_UP])     r.speed_operation = OP_UP2;
                        else if (rise[BTN_SET])    r.speed_operation =
                            (it.display_speed > it.set_speed) ? OP_SET : OP_DOWN1;
                        else if (rise[BTN_RESUME]) r.speed_operation = OP_UP1;
                    end else begin
                        if (rise[BTN_SET])         r.speed_operation = OP_SET;
                        else if (rise[BTN_DOWN])   r.speed_operation = OP_DOWN2;
                        else if (rise[BTN_UP])     r.speed_operation = OP_UP2;
                        else if (rise[BTN_RESUME]) r.speed_operation = OP_UP1;
                    end
                end
            end
        endcase
        if (it.machine_state != ST_OFF && rise[BTN_HEAD]) begin
            hw_stage = (hw_stage == HEADWAY_MAX_STAGE) ? 4'd0 : hw_stage + 4'd1;
        end
        prev_btn = b;
        pct = hw_stage * PCT_FULL / HEADWAY_MAX_STAGE;
        if (pct > PCT_FULL) begin
            pct = PCT_FULL;
        end
        r.headway_percent = pct[6:0];
        r.start_confirm = confirm_q;
        r.degraded = |it.stability_failures;
        return r;
    endfunction

    function automatic t_in_item quiet_tick(input logic [1:0] st, input logic [6:0] btn);
        t_in_item it;
        it = '0;
        it.machine_state = st;
        it.buttons = btn;
        it.gear_forward = 1'b1;
        it.display_speed = 9'd100;
        it.set_speed = 9'd100;
        return it;
    endfunction

    function automatic t_in_item random_tick();
        t_in_item    it;
        logic [63:0] raw;
        int unsigned pick;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        if ($urandom_range(0, 99) < 6) begin
            walk_state = 2'($urandom_range(0, 3));
        end
        if ($urandom_range(0, 99) < 75) begin
            pick = $urandom_range(0, 9);
            it.machine_state = walk_state;
            it.buttons = (pick < 7) ? (7'd1 << pick) : 7'd0;
            if (walk_state != ST_OFF && $urandom_range(0, 3) != 0) begin
                it.buttons[BTN_MAIN] = 1'b1;
            end
            it.park_brake = ($urandom_range(0, 19) == 0);
            it.gear_forward = ($urandom_range(0, 19) != 0);
            it.brake_pedal = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 2) != 0) begin
                it.stability_failures = 3'd0;
            end
            if ($urandom_range(0, 7) == 0) begin
                it.display_speed = it.set_speed;
            end
        end
        return it;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            end
        end
    endtask

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (expected_cmds.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("%0t ns: result expected none, got %h", $time, out_ch.data);
                end
            end else begin
                want = expected_cmds.pop_front();
                check_field("display_state", 32'(want.display_state),
                            32'(out_ch.data.display_state));
                check_field("cmd_on", 32'(want.cmd_on), 32'(out_ch.data.cmd_on));
                check_field("cmd_off", 32'(want.cmd_off), 32'(out_ch.data.cmd_off));
                check_field("cmd_activate", 32'(want.cmd_activate),
                            32'(out_ch.data.cmd_activate));
                check_field("cmd_deactivate", 32'(want.cmd_deactivate),
                            32'(out_ch.data.cmd_deactivate));
                check_field("speed_operation", 32'(want.speed_operation),
                            32'(out_ch.data.speed_operation));
                check_field("start_confirm", 32'(want.start_confirm),
                            32'(out_ch.data.start_confirm));
                check_field("headway_percent", 32'(want.headway_percent),
                            32'(out_ch.data.headway_percent));
                check_field("degraded", 32'(want.degraded), 32'(out_ch.data.degraded));
            end
        end
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 19);
    end

    task automatic send_tick(input t_in_item it);
        while (!steady && $urandom_range(0, 99) < 19) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge clk);
        while (!in_ch.ready) begin
            @(posedge clk);
        end
        expected_cmds.push_back(hmi_command_for(it));
    endtask

    task automatic stop_send();
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (expected_cmds.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Hold the input until the block is empty, then load a new initial stage
    task automatic reconfigure(input logic [3:0] value);
        stop_send();
        wait_drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready) begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        hw_init = value;
    endtask

    task automatic test_ready_commands();
        t_in_item it;
        send_tick(quiet_tick(ST_READY, MASK_MAIN));
        send_tick(quiet_tick(ST_READY, MASK_MAIN | MASK_HEAD));
        send_tick(quiet_tick(ST_READY, 7'd0));
        it = quiet_tick(ST_READY, MASK_MAIN | MASK_SET);
        it.speed_stored = 1'b1;
        it.stability_failures = 3'd1;
        send_tick(it);
        it.stability_failures = 3'd4;
        send_tick(it);
        it = quiet_tick(ST_READY, MASK_MAIN | MASK_UP);
        it.park_brake = 1'b1;
        send_tick(it);
        it = quiet_tick(ST_READY, MASK_MAIN | MASK_DOWN);
        it.brake_pedal = 1'b1;
        it.stand_still = 1'b1;
        send_tick(it);
        it = quiet_tick(ST_READY, MASK_MAIN | MASK_RESUME);
        it.gear_forward = 1'b0;
        send_tick(it);
    endtask

    task automatic test_active_operations();
        t_in_item it;
        it = quiet_tick(ST_ACTIVE, 7'd0);
        it.accel_pedal = 1'b1;
        it.stability_failures = 3'd2;
        send_tick(it);
        send_tick(quiet_tick(ST_ACTIVE, MASK_DOWN | MASK_UP | MASK_SET | MASK_RESUME));
        send_tick(quiet_tick(ST_ACTIVE, 7'd0));
        send_tick(quiet_tick(ST_ACTIVE, MASK_UP | MASK_RESUME));
        it = quiet_tick(ST_ACTIVE, MASK_SET | MASK_RESUME);
        it.display_speed = 9'd511;
        it.set_speed = 9'd0;
        send_tick(it);
        it = quiet_tick(ST_ACTIVE, 7'd0);
        it.brake_pedal = 1'b1;
        send_tick(it);
        send_tick(quiet_tick(ST_ACTIVE, MASK_SET));
        send_tick(quiet_tick(ST_ACTIVE, MASK_RESUME));
        it = quiet_tick(ST_ACTIVE, MASK_CANCEL);
        it.stability_failures = 3'd7;
        send_tick(it);
        it = quiet_tick(ST_ACTIVE, 7'd0);
        it.accel_pedal = 1'b1;
        send_tick(it);
        send_tick(quiet_tick(ST_READY, MASK_MAIN));
        send_tick(quiet_tick(ST_OFF, MASK_MAIN));
    endtask

    task automatic test_override_operations();
        t_in_item it;
        send_tick(quiet_tick(ST_OVERRIDE, MASK_DOWN | MASK_UP | MASK_SET | MASK_RESUME));
        it = quiet_tick(ST_OVERRIDE, 7'd0);
        it.gear_forward = 1'b0;
        send_tick(it);
        send_tick(quiet_tick(ST_OVERRIDE, MASK_DOWN | MASK_UP | MASK_RESUME));
        it = quiet_tick(ST_OVERRIDE, 7'd0);
        it.park_brake = 1'b1;
        send_tick(it);
        send_tick(quiet_tick(ST_OVERRIDE, MASK_UP | MASK_RESUME));
        send_tick(quiet_tick(ST_OVERRIDE, 7'd0));
        send_tick(quiet_tick(ST_OVERRIDE, MASK_RESUME));
    endtask

    task automatic test_headway_stage();
        reconfigure(4'd15);
        send_tick(quiet_tick(ST_OFF, 7'd0));
        send_tick(quiet_tick(ST_READY, MASK_MAIN | MASK_HEAD));
        reconfigure(4'd4);
        send_tick(quiet_tick(ST_READY, MASK_MAIN));
        send_tick(quiet_tick(ST_OFF, 7'd0));
        send_tick(quiet_tick(ST_READY, MASK_MAIN | MASK_HEAD));
        reconfigure(4'd3);
        send_tick(quiet_tick(ST_OFF, 7'd0));
        send_tick(quiet_tick(ST_ACTIVE, MASK_HEAD));
        reconfigure(4'd0);
        send_tick(quiet_tick(ST_OFF, 7'd0));
        send_tick(quiet_tick(ST_OVERRIDE, MASK_HEAD));
    endtask

    task automatic test_random_traffic();
        logic [3:0] stage_setting[6];
        stage_setting = '{4'd2, 4'd15, 4'd0, 4'd3, 4'd1, 4'($urandom_range(4, 14))};
        for (int phase = 0; phase < 6; phase++) begin
            reconfigure(stage_setting[phase]);
            steady = (phase == 2);
            repeat (RANDOM_PHASE_TICKS) begin
                send_tick(random_tick());
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        errors = 0;
        cycles = 0;
        steady = 1'b0;
        walk_state = ST_READY;
        hw_init = HEADWAY_INIT_RESET;
        hw_stage = HEADWAY_INIT_RESET;
        prev_btn = '0;
        confirm_q = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ready_commands();
        test_active_operations();
        test_override_operations();
        test_headway_stage();
        test_random_traffic();

        stop_send();
        wait_drain();
        repeat (8) @(posedge clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
